@@ rtl/core/ttw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types and constants for the text to tile-map writer.
// ----------------------------------------------------------------------------
package ttw_pkg;

    // default geometry
    localparam int MAP_WIDTH_DEF      = 32;
    localparam int MAP_HEIGHT_DEF     = 32;
    localparam int MAX_CELL_TILES_DEF = 4;

    // most map writes one character may cause
    localparam int MAX_WRITES = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST_GLYPH  = 3'd0;
    localparam logic [2:0] CFG_LAST_GLYPH   = 3'd1;
    localparam logic [2:0] CFG_ATLAS_COLS   = 3'd2;
    localparam logic [2:0] CFG_ATLAS_STRIDE = 3'd3;
    localparam logic [2:0] CFG_CELL_WIDE    = 3'd4;
    localparam logic [2:0] CFG_CELL_HIGH    = 3'd5;
    localparam logic [2:0] CFG_PALETTE      = 3'd6;

    // configuration reset values
    localparam logic [6:0] FIRST_GLYPH_RST  = 7'd32;
    localparam logic [6:0] LAST_GLYPH_RST   = 7'd127;
    localparam logic [6:0] ATLAS_COLS_RST   = 7'd16;
    localparam logic [7:0] ATLAS_STRIDE_RST = 8'd16;
    localparam logic [2:0] CELL_WIDE_RST    = 3'd1;
    localparam logic [2:0] CELL_HIGH_RST    = 3'd1;
    localparam logic [3:0] PALETTE_RST      = 4'd0;

    // control characters
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;

    // sequencer states
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_ROWCHK = 11'b000_0000_0100,
        S_COLCHK = 11'b000_0000_1000,
        S_DIV    = 11'b000_0001_0000,
        S_MULQ   = 11'b000_0010_0000,
        S_MULS   = 11'b000_0100_0000,
        S_MULR   = 11'b000_1000_0000,
        S_MULA   = 11'b001_0000_0000,
        S_EMIT   = 11'b010_0000_0000,
        S_SPARE  = 11'b100_0000_0000
    } ttw_state_t;

endpackage

@@ rtl/core/text_to_tilemap_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_to_tilemap_writer_core
// Turns a stream of text bytes into tile-map entry writes for a text layer.
// ----------------------------------------------------------------------------
// One input item is taken at a time. A newline, a tab or a character of a
// stopped string ends in the decode step; a character whose cell lies off
// the grid ends in the row or column check. A printable character that lands
// on the grid makes n = min(cell width * cell height, 16) map writes: one
// shared 16x8 multiplier performs the grid checks, the glyph base and the map
// address arithmetic in turn, a restoring divider splits the glyph index by
// the atlas column count, and one map write leaves per cycle while the result
// side keeps up. The last write sits in the output register while the next
// item is already accepted.
module text_to_tilemap_writer_core
    import ttw_pkg::*;
#(
    parameter int MAP_WIDTH      = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT     = MAP_HEIGHT_DEF,
    parameter int MAX_CELL_TILES = MAX_CELL_TILES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // character items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic [4:0]  s_origin_col,
    input  logic [4:0]  s_origin_row,
    input  logic        s_string_start,
    // map write items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_map_address,
    output logic [15:0] m_map_entry,
    output logic        m_last_write
);

    localparam int CW_W = $clog2(MAX_CELL_TILES + 1);

    // configuration registers
    logic [6:0] first_glyph_reg;
    logic [6:0] last_glyph_reg;
    logic [6:0] atlas_cols_reg;
    logic [7:0] atlas_stride_reg;
    logic [2:0] cell_wide_reg;
    logic [2:0] cell_high_reg;
    logic [3:0] palette_reg;

    // cursor state
    logic [5:0] cursor_col_reg, cursor_col_next;
    logic [5:0] cursor_row_reg, cursor_row_next;
    logic [4:0] home_col_reg, home_col_next;
    logic       stopped_reg, stopped_next;

    // sequencer and working registers
    ttw_state_t      state_reg, state_next;
    logic [7:0]      code_reg, code_next;
    logic [9:0]      tx_reg, tx_next;
    logic [9:0]      ty_reg, ty_next;
    logic [7:0]      div_rem_reg, div_rem_next;
    logic [6:0]      div_quo_reg, div_quo_next;
    logic [2:0]      div_cnt_reg, div_cnt_next;
    logic [15:0]     acc_reg, acc_next;
    logic [15:0]     row_tile_reg, row_tile_next;
    logic [9:0]      row_addr_reg, row_addr_next;
    logic [CW_W-1:0] dx_reg, dx_next;
    logic [CW_W-1:0] dy_reg, dy_next;
    logic [3:0]      wcnt_reg, wcnt_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [9:0]  out_addr_reg, out_addr_next;
    logic [15:0] out_entry_reg, out_entry_next;
    logic        out_last_reg, out_last_next;

    // shared multiplier
    logic [15:0] mul_a;
    logic [7:0]  mul_b;
    logic [23:0] mul_full;
    logic [15:0] mul_p;

    // derived configuration
    logic [CW_W-1:0] cw_eff, ch_eff;
    logic [6:0]      cols_eff;
    logic            code_in_range;
    logic [6:0]      glyph_idx;

    // divider step
    logic [7:0] div_trial;
    logic       div_ge;

    // misc
    logic [6:0] row_inc, col_inc, tab_sum;
    logic       out_free, emit_last, dx_end, dy_end;
    logic       s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_map_address = out_addr_reg;
    assign m_map_entry   = out_entry_reg;
    assign m_last_write  = out_last_reg;

    // cell size clamp to one..MAX_CELL_TILES
    always_comb begin
        if (cell_wide_reg == 3'd0) begin
            cw_eff = CW_W'(1);
        end else if (int'(cell_wide_reg) > MAX_CELL_TILES) begin
            cw_eff = CW_W'(MAX_CELL_TILES);
        end else begin
            cw_eff = CW_W'(cell_wide_reg);
        end
        if (cell_high_reg == 3'd0) begin
            ch_eff = CW_W'(1);
        end else if (int'(cell_high_reg) > MAX_CELL_TILES) begin
            ch_eff = CW_W'(MAX_CELL_TILES);
        end else begin
            ch_eff = CW_W'(cell_high_reg);
        end
    end

    // glyph index into the atlas, out-of-range codes fall back to the first glyph
    assign cols_eff      = (atlas_cols_reg == 7'd0) ? 7'd1 : atlas_cols_reg;
    assign code_in_range = !code_reg[7] && (code_reg[6:0] >= first_glyph_reg)
                           && (code_reg[6:0] <= last_glyph_reg);
    assign glyph_idx     = code_in_range ? (code_reg[6:0] - first_glyph_reg) : 7'd0;

    // restoring divide step
    assign div_trial = {div_rem_reg[6:0], div_quo_reg[6]};
    assign div_ge    = (div_trial >= {1'b0, cols_eff});

    // cursor helpers
    assign row_inc = {1'b0, cursor_row_reg} + 7'd1;
    assign col_inc = {1'b0, cursor_col_reg} + 7'd1;
    assign tab_sum = ({1'b0, cursor_col_reg} + 7'd4) & 7'b111_1100;

    // emit helpers
    assign out_free  = !m_valid_reg || m_ready;
    assign dx_end    = (dx_reg == CW_W'(cw_eff - 1'b1));
    assign dy_end    = (dy_reg == CW_W'(ch_eff - 1'b1));
    assign emit_last = (wcnt_reg == 4'(MAX_WRITES - 1)) || (dx_end && dy_end);

    // shared multiplier operand selection
    always_comb begin
        mul_a = 16'd0;
        mul_b = 8'd0;
        unique case (state_reg)
            S_DECODE, S_COLCHK: begin
                mul_a = {9'd0, col_inc};
                mul_b = 8'(cw_eff);
            end
            S_ROWCHK: begin
                mul_a = {9'd0, row_inc};
                mul_b = 8'(ch_eff);
            end
            S_MULQ: begin
                mul_a = {9'd0, div_quo_reg};
                mul_b = 8'(ch_eff);
            end
            S_MULS: begin
                mul_a = acc_reg;
                mul_b = atlas_stride_reg;
            end
            S_MULR: begin
                mul_a = {8'd0, div_rem_reg};
                mul_b = 8'(cw_eff);
            end
            S_MULA: begin
                mul_a = {6'd0, ty_reg};
                mul_b = 8'(MAP_WIDTH);
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 8'd0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[15:0];

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        home_col_next   = home_col_reg;
        stopped_next    = stopped_reg;
        code_next       = code_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_cnt_next    = div_cnt_reg;
        acc_next        = acc_reg;
        row_tile_next   = row_tile_reg;
        row_addr_next   = row_addr_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        wcnt_next       = wcnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_addr_next   = out_addr_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    code_next = s_char_code;
                    if (s_string_start) begin
                        cursor_col_next = {1'b0, s_origin_col};
                        cursor_row_next = {1'b0, s_origin_row};
                        home_col_next   = s_origin_col;
                        stopped_next    = 1'b0;
                    end
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stopped_reg) begin
                    state_next = S_IDLE;
                end else if (code_reg == CHAR_NEWLINE) begin
                    cursor_col_next = {1'b0, home_col_reg};
                    cursor_row_next = row_inc[6] ? 6'd63 : row_inc[5:0];
                    state_next      = S_IDLE;
                end else if (code_reg == CHAR_TAB) begin
                    cursor_col_next = tab_sum[6] ? 6'd63 : tab_sum[5:0];
                    state_next      = S_IDLE;
                end else begin
                    // wrap past the right edge of the cell grid
                    if (mul_p > 16'(MAP_WIDTH)) begin
                        cursor_col_next = {1'b0, home_col_reg};
                        cursor_row_next = row_inc[6] ? 6'd63 : row_inc[5:0];
                    end
                    state_next = S_ROWCHK;
                end
            end
            S_ROWCHK: begin
                // bottom edge stops the rest of the string
                if (mul_p > 16'(MAP_HEIGHT)) begin
                    stopped_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    ty_next    = 10'(mul_p - 16'(ch_eff));
                    state_next = S_COLCHK;
                end
            end
            S_COLCHK: begin
                cursor_col_next = col_inc[6] ? 6'd63 : col_inc[5:0];
                if (mul_p > 16'(MAP_WIDTH)) begin
                    state_next = S_IDLE;
                end else begin
                    tx_next      = 10'(mul_p - 16'(cw_eff));
                    div_rem_next = 8'd0;
                    div_quo_next = glyph_idx;
                    div_cnt_next = 3'd0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                div_rem_next = div_ge ? (div_trial - {1'b0, cols_eff}) : div_trial;
                div_quo_next = {div_quo_reg[5:0], div_ge};
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd6) begin
                    state_next = S_MULQ;
                end
            end
            S_MULQ: begin
                acc_next   = mul_p;
                state_next = S_MULS;
            end
            S_MULS: begin
                acc_next   = mul_p;
                state_next = S_MULR;
            end
            S_MULR: begin
                row_tile_next = acc_reg + mul_p + 16'd1;
                state_next    = S_MULA;
            end
            S_MULA: begin
                row_addr_next = mul_p[9:0] + tx_reg;
                dx_next       = '0;
                dy_next       = '0;
                wcnt_next     = 4'd0;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_addr_next  = row_addr_reg + 10'(dx_reg);
                    out_entry_next = (row_tile_reg + 16'(dx_reg)) | {palette_reg, 12'd0};
                    out_last_next  = emit_last;
                    wcnt_next      = wcnt_reg + 4'd1;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end else if (dx_end) begin
                        dx_next       = '0;
                        dy_next       = dy_reg + 1'b1;
                        row_tile_next = row_tile_reg + 16'(atlas_stride_reg);
                        row_addr_next = row_addr_reg + 10'(MAP_WIDTH);
                    end else begin
                        dx_next = dx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cursor_col_reg <= 6'd0;
            cursor_row_reg <= 6'd0;
            home_col_reg   <= 5'd0;
            stopped_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            home_col_reg   <= home_col_next;
            stopped_reg    <= stopped_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_cnt_reg   <= div_cnt_next;
        acc_reg       <= acc_next;
        row_tile_reg  <= row_tile_next;
        row_addr_reg  <= row_addr_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        wcnt_reg      <= wcnt_next;
        out_addr_reg  <= out_addr_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_glyph_reg  <= FIRST_GLYPH_RST;
            last_glyph_reg   <= LAST_GLYPH_RST;
            atlas_cols_reg   <= ATLAS_COLS_RST;
            atlas_stride_reg <= ATLAS_STRIDE_RST;
            cell_wide_reg    <= CELL_WIDE_RST;
            cell_high_reg    <= CELL_HIGH_RST;
            palette_reg      <= PALETTE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FIRST_GLYPH:  first_glyph_reg  <= cfg_data[6:0];
                CFG_LAST_GLYPH:   last_glyph_reg   <= cfg_data[6:0];
                CFG_ATLAS_COLS:   atlas_cols_reg   <= cfg_data[6:0];
                CFG_ATLAS_STRIDE: atlas_stride_reg <= cfg_data;
                CFG_CELL_WIDE:    cell_wide_reg    <= cfg_data[2:0];
                CFG_CELL_HIGH:    cell_high_reg    <= cfg_data[2:0];
                CFG_PALETTE:      palette_reg      <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // new map writes are only loaded by the emit step
    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == S_EMIT))
        else $error("map write loaded outside the emit step");

    // column and row counters stay inside the cell while emitting
    a_dx_in_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (dx_reg < cw_eff) && (dy_reg < ch_eff))
        else $error("tile offset outside the glyph cell");

    // a final write always hands control back to the idle step
    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free && emit_last) |=> (state_reg == S_IDLE))
        else $error("emit continued after the final write");

endmodule
